// ----- rtl/tkip_michael_mic_engine_defines.svh -----
// Assertion macros shared by the Michael MIC engine RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef TKIP_MICHAEL_MIC_ENGINE_DEFINES_SVH
`define TKIP_MICHAEL_MIC_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define TMIC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tmic: assertion failed");
`define TMIC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tmic: assertion failed");
`else
`define TMIC_ASSERT(lbl, prop)
`define TMIC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- rtl/tmic_pkg.sv -----
package tmic_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam int IN_DATA_W  = 272;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 64;
	localparam int KEY_W      = 64;

	localparam logic [7:0] PAD_BYTE = 8'h5a;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_DATA   = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_t;

	typedef enum logic {
		REG_TX_KEY = 1'b0,
		REG_RX_KEY = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_WORD   = 2'd1,
		OP_FINISH = 2'd2
	} op_kind_t;

	// One queued job for the Michael back end.
	// START: seed from key, then run words[0..3].
	// WORD: run words[0].
	// FINISH: run words[0] and words[1], then compare against peer.
	typedef struct packed {
		op_kind_t         kind;
		logic             verify;
		logic [63:0]      key;
		logic [63:0]      peer;
		logic [3:0][31:0] words;
	} op_t;

endpackage

// ----- rtl/tkip_michael_mic_engine.sv -----
// Channel   Dir  Width     Contents
// s_*       in   272 + 2   header / payload byte / finish command
// m_*       out  64 + 1    MIC and mismatch flag
// cfg_*     in   1 + 64    transmit and receive Michael keys
//
// Payload bytes are taken one per cycle while the queue has room; every
// fourth byte queues one Michael block, which the back end runs as a load
// plus two half-block steps, two 32-bit adds each.
// A start runs four words and a finish two words; the front keeps
// accepting until the op queue (QueueDepth entries) is full.
// Reset clears keys, Michael state, byte gather and the queue at once.
// m_tready low holds the result in the output register; a later finish waits
// in the back end at delivery and the queue backs up into s_tready.
module tkip_michael_mic_engine #(
	parameter int QueueDepth = tmic_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [tmic_pkg::KEY_W-1:0]      cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// addr_one, addr_two, addr_three, addr_four, to_ds, from_ds, qos_data,
	// tid, check_mode, payload_byte, peer_mic
	input  logic [tmic_pkg::IN_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic [tmic_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// mic_value
	output logic [tmic_pkg::OUT_DATA_W-1:0] m_tdata,
	// mic_mismatch
	output logic [0:0]                      m_tuser
);

	logic          push, pop, full, empty;
	tmic_pkg::op_t push_op, head;

	tmic_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.full      (full),
		.push      (push),
		.push_op   (push_op)
	);

	tmic_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.pop     (pop),
		.head    (head),
		.empty   (empty)
	);

	tmic_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- rtl/tmic_front.sv -----
module tmic_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [tmic_pkg::KEY_W-1:0]       cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tmic_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [tmic_pkg::IN_USER_W-1:0]   s_tuser,
	input  logic                             full,
	output logic                             push,
	output tmic_pkg::op_t                    push_op
);

	logic [63:0] tx_key_q;
	logic [63:0] rx_key_q;
	logic [23:0] gather_q;
	logic [1:0]  gcount_q;

	logic        accept;
	logic [47:0] a1, a2, a3, a4, da, sa;
	logic        to_ds, from_ds, qos, check;
	logic [3:0]  tid;
	logic [7:0]  pbyte;
	logic [63:0] peer;
	logic [31:0] byte_shift;
	logic [31:0] pad_word;
	tmic_pkg::cmd_t cmd;

	assign a1      = s_tdata[47:0];
	assign a2      = s_tdata[95:48];
	assign a3      = s_tdata[143:96];
	assign a4      = s_tdata[191:144];
	assign to_ds   = s_tdata[192];
	assign from_ds = s_tdata[193];
	assign qos     = s_tdata[194];
	assign tid     = s_tdata[198:195];
	assign check   = s_tdata[199];
	assign pbyte   = s_tdata[207:200];
	assign peer    = s_tdata[271:208];
	assign cmd     = tmic_pkg::cmd_t'(s_tuser);

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		unique case ({from_ds, to_ds})
			2'b00: begin da = a1; sa = a2; end
			2'b01: begin da = a3; sa = a2; end
			2'b10: begin da = a1; sa = a3; end
			default: begin da = a3; sa = a4; end
		endcase
	end

	assign byte_shift = {24'h0, pbyte} << {gcount_q, 3'b000};
	// pending bytes above the count are always zero, so OR-ing in the pad is safe
	assign pad_word = {8'h00, gather_q} | ({24'h0, tmic_pkg::PAD_BYTE} << {gcount_q, 3'b000});

	always_comb begin
		push_op = '0;
		push    = 1'b0;
		unique case (cmd)
			tmic_pkg::CMD_START: begin
				push            = accept;
				push_op.kind    = tmic_pkg::OP_START;
				push_op.verify  = check;
				push_op.key     = check ? rx_key_q : tx_key_q;
				push_op.words[0] = da[31:0];
				push_op.words[1] = {sa[15:0], da[47:32]};
				push_op.words[2] = sa[47:16];
				push_op.words[3] = qos ? {28'h0, tid} : 32'h0;
			end
			tmic_pkg::CMD_DATA: begin
				push             = accept && (gcount_q == 2'd3);
				push_op.kind     = tmic_pkg::OP_WORD;
				push_op.words[0] = {pbyte, gather_q};
			end
			tmic_pkg::CMD_FINISH: begin
				push             = accept;
				push_op.kind     = tmic_pkg::OP_FINISH;
				push_op.peer     = peer;
				push_op.words[0] = pad_word;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_key_q <= '0;
			rx_key_q <= '0;
			gather_q <= '0;
			gcount_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (tmic_pkg::reg_idx_t'(cfg_index))
					tmic_pkg::REG_TX_KEY: tx_key_q <= cfg_wdata;
					tmic_pkg::REG_RX_KEY: rx_key_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				case (cmd)
					tmic_pkg::CMD_START, tmic_pkg::CMD_FINISH: begin
						gather_q <= '0;
						gcount_q <= '0;
					end
					tmic_pkg::CMD_DATA: begin
						if (gcount_q == 2'd3) begin
							gather_q <= '0;
							gcount_q <= '0;
						end else begin
							gather_q <= gather_q | byte_shift[23:0];
							gcount_q <= gcount_q + 2'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- rtl/tmic_queue.sv -----
`include "tkip_michael_mic_engine_defines.svh"

module tmic_queue #(
	parameter int Depth = tmic_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tmic_pkg::op_t push_op,
	output logic          full,
	input  logic          pop,
	output tmic_pkg::op_t head,
	output logic          empty
);

	localparam int IdxW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	tmic_pkg::op_t   mem_q [Depth];
	logic [IdxW-1:0] wr_ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	`TMIC_ASSERT(a_no_overflow, !(push && full))
	`TMIC_ASSERT(a_no_underflow, !(pop && empty))
	`TMIC_ASSERT(a_count_bound, count_q <= CntW'(Depth))
	`TMIC_ASSERT_NEXT(a_push_not_empty, push && !pop, !empty)

endmodule

// ----- rtl/tmic_back.sv -----
module tmic_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tmic_pkg::op_t                   head,
	input  logic                            empty,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tmic_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [0:0]                      m_tuser
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} back_st_t;

	back_st_t      st_q;
	tmic_pkg::op_t cur_q;
	logic [2:0]    step_q;
	logic [31:0]   l_q, r_q;
	logic          verify_q;
	logic          m_valid_q;
	logic [63:0]   m_data_q;
	logic          m_mis_q;

	logic [31:0] w, l1, r1, l2, r2, l3, r3, l4, r4, l5;
	logic [31:0] l_next, r_next;
	logic        last_half, deliver, out_free, fire;
	logic [63:0] mic;

	assign pop      = (st_q == ST_IDLE) && !empty;
	assign out_free = !m_valid_q || m_tready;
	assign deliver  = (cur_q.kind == tmic_pkg::OP_FINISH) && (step_q == 3'd4);
	assign fire     = (st_q == ST_RUN) && deliver && out_free;
	assign mic      = {r_q, l_q};

	always_comb begin
		case (cur_q.kind)
			tmic_pkg::OP_START:  last_half = (step_q == 3'd7);
			tmic_pkg::OP_WORD:   last_half = (step_q == 3'd1);
			tmic_pkg::OP_FINISH: last_half = (step_q == 3'd3);
			default:             last_half = 1'b1;
		endcase
	end

	// Michael block split in two halves, two adds each.
	assign w  = cur_q.words[step_q[2:1]];
	assign l1 = l_q ^ w;
	assign r1 = r_q ^ {l1[14:0], l1[31:15]};
	assign l2 = l1 + r1;
	assign r2 = r1 ^ {l2[23:16], l2[31:24], l2[7:0], l2[15:8]};
	assign l3 = l2 + r2;

	assign r3 = r_q ^ {l_q[28:0], l_q[31:29]};
	assign l4 = l_q + r3;
	assign r4 = r3 ^ {l4[1:0], l4[31:2]};
	assign l5 = l4 + r4;

	assign l_next = step_q[0] ? l5 : l3;
	assign r_next = step_q[0] ? r4 : r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			step_q    <= '0;
			l_q       <= '0;
			r_q       <= '0;
			verify_q  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			m_valid_q <= fire || (m_valid_q && !m_tready);
			unique case (st_q)
				ST_IDLE: begin
					if (!empty) begin
						st_q   <= ST_RUN;
						step_q <= '0;
						if (head.kind == tmic_pkg::OP_START) begin
							l_q      <= head.key[31:0];
							r_q      <= head.key[63:32];
							verify_q <= head.verify;
						end
					end
				end
				ST_RUN: begin
					if (deliver) begin
						if (out_free) begin
							st_q <= ST_IDLE;
						end
					end else begin
						l_q    <= l_next;
						r_q    <= r_next;
						step_q <= step_q + 3'd1;
						if (last_half && cur_q.kind != tmic_pkg::OP_FINISH) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (fire) begin
			m_data_q <= mic;
			m_mis_q  <= verify_q && (mic != cur_q.peer);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_mis_q;

endmodule
